/* src/csfa_pkg.sv */
// Package for the CAN signal frame assigner: frame slot entry type, sequencer
// state type and stream payload widths. No dependencies.
package csfa_pkg;

   localparam int CSFA_NUM_SIGNALS = 32;

   localparam int REQ_DATA_W = 56;   // 49 payload bits, padded to whole bytes
   localparam int RSP_DATA_W = 16;   // 12 payload bits, padded to whole bytes

   localparam int ID_W    = 29;
   localparam int LEN_W   = 4;
   localparam int MAX_LEN = 8;

   // One frame slot as held in the frame table memory.
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             ext;
      logic [ID_W-1:0]  id;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

/* src/csfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module csfa_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* src/can_signal_frame_assigner.sv */
// CAN signal frame assigner top level: request decode, slot scan sequencer,
// frame table valid bits and result register. Uses csfa_pkg and csfa_ram.
//
// Each request transfer describes one signal; the block answers with exactly
// one response transfer naming the frame slot the signal was packed into.
// A set "first" bit empties the frame table before the signal is handled.
// An enabled signal with an index below NUM_SIGNALS joins the lowest used
// slot with the same identifier and format (its length grows, never shrinks)
// or, failing that, claims the lowest free slot. A signal that is disabled or
// out of range skips the scan; the scan reads the frame table through its
// single read port, one slot per cycle. One request is handled at a time:
// req_tready is high only while the sequencer is idle. The response
// register decouples the two sides, so a new request is taken while a
// response still waits; a finished request holds in its last step until
// the response register is free. Slot occupancy lives in per-slot
// flip-flops, so reset and "first" empty the table at once with no
// clearing pass.
module can_signal_frame_assigner #(
   parameter int NUM_SIGNALS = csfa_pkg::CSFA_NUM_SIGNALS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: [0] first, [5:1] signal_index, [6] enabled, [35:7] frame_id,
   //          [41:36] start_bit, [48:42] bit_length, [55:49] zero
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [csfa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,   // [0] extended_id
   // response: [0] assigned, [5:1] slot, [6] reused, [10:7] frame_length,
   //           [11] length_error, [15:12] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [csfa_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import csfa_pkg::*;

   localparam int SLOT_W = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
   localparam int CNT_W  = $clog2(NUM_SIGNALS + 1);
   localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(NUM_SIGNALS);
   localparam logic [6:0]       IDX_LIMIT = 7'(NUM_SIGNALS);

   // request fields
   logic            req_first;
   logic [4:0]      req_index;
   logic            req_enabled;
   logic [ID_W-1:0] req_id;
   logic [5:0]      req_start;
   logic [6:0]      req_nbits;

   assign req_first   = req_tdata[0];
   assign req_index   = req_tdata[5:1];
   assign req_enabled = req_tdata[6];
   assign req_id      = req_tdata[35:7];
   assign req_start   = req_tdata[41:36];
   assign req_nbits   = req_tdata[48:42];

   // sequencer and item registers
   state_type         state_ff, state_in;
   logic              ext_ff, ext_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [LEN_W-1:0]  need_ff, need_in;
   logic              lerr_ff, lerr_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0] chk_slot_ff, chk_slot_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic [LEN_W-1:0]  hit_len_ff, hit_len_in;
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] free_slot_ff, free_slot_in;
   logic [NUM_SIGNALS-1:0] valid_ff, valid_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // frame table port signals
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   entry_type         ram_rd_data;

   logic              req_fire;
   logic              rsp_free;
   logic              item_go;
   logic [7:0]        bit_total;
   logic [4:0]        need_raw;
   logic              scan_more;
   logic              chk_used;
   logic              chk_match;
   logic [LEN_W-1:0]  grown_len;
   logic              done_assigned;
   logic [SLOT_W-1:0] done_slot;
   logic [SLOT_W+4:0] done_slot_wide;
   logic [LEN_W-1:0]  done_len;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Byte count of the signal: last bit / 8 + 1, with an empty span as one byte.
   assign bit_total = {2'b00, req_start} + {1'b0, req_nbits};
   assign need_raw  = (bit_total == 8'd0) ? 5'd1
                    : 5'(((bit_total - 8'd1) >> 3) + 8'd1);
   assign item_go   = req_enabled && ({2'b00, req_index} < IDX_LIMIT);

   assign scan_more = (scan_ff < SCAN_END);
   assign chk_used  = valid_ff[chk_slot_ff];
   assign chk_match = chk_used && (ram_rd_data.ext == ext_ff) && (ram_rd_data.id == id_ff);

   assign grown_len     = (hit_len_ff < need_ff) ? need_ff : hit_len_ff;
   assign done_assigned = hit_ff || free_ff;
   assign done_slot     = hit_ff ? hit_slot_ff : free_slot_ff;
   assign done_len      = hit_ff ? grown_len : need_ff;
   assign done_slot_wide = {5'b00000, done_slot};

   csfa_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_SIGNALS)
   ) u_frame_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = item_go ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // the last slot is compared in the cycle the counter reaches the end
            if (!scan_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and table control
   always_comb begin
      ext_in        = ext_ff;
      id_in         = id_ff;
      need_in       = need_ff;
      lerr_in       = lerr_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_slot_in   = chk_slot_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_len_in    = hit_len_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      valid_in      = valid_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = done_slot;
      ram_wr_data   = '{len: done_len, ext: ext_ff, id: id_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_ff[SLOT_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ext_in  = req_tuser;
               id_in   = req_id;
               // clamp to a classic CAN payload
               need_in = (need_raw > 5'(MAX_LEN)) ? LEN_W'(MAX_LEN) : need_raw[LEN_W-1:0];
               lerr_in = (need_raw > 5'(MAX_LEN));
               scan_in = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               if (req_first) begin
                  valid_in = '0;
               end
            end
         end
         ST_SCAN: begin
            // issue the read for the next slot
            if (scan_more) begin
               ram_rd_en   = 1'b1;
               scan_in     = scan_ff + CNT_W'(1);
               chk_vld_in  = 1'b1;
               chk_slot_in = scan_ff[SLOT_W-1:0];
            end
            // compare the slot read last cycle; keep the lowest of each kind
            if (chk_vld_ff) begin
               if (chk_match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = chk_slot_ff;
                  hit_len_in  = ram_rd_data.len;
               end
               if (!chk_used && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = chk_slot_ff;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               ram_wr_en = done_assigned;
               if (!hit_ff && free_ff) begin
                  valid_in[free_slot_ff] = 1'b1;
               end
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = '0;
               if (done_assigned) begin
                  rsp_data_in[0]    = 1'b1;
                  rsp_data_in[5:1]  = done_slot_wide[4:0];
                  rsp_data_in[6]    = hit_ff;
                  rsp_data_in[10:7] = done_len;
                  rsp_data_in[11]   = lerr_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         scan_ff       <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      ext_ff       <= ext_in;
      id_ff        <= id_in;
      need_ff      <= need_in;
      lerr_ff      <= lerr_in;
      chk_slot_ff  <= chk_slot_in;
      hit_slot_ff  <= hit_slot_in;
      hit_len_ff   <= hit_len_in;
      free_slot_ff <= free_slot_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // a request with "first" leaves an empty table behind
   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_first) |=> (valid_ff == '0))
      else $error("frame table not emptied by first");

   // at most one slot is claimed per request
   a_one_claim: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=>
         ($countones(valid_ff) <= $countones($past(valid_ff)) + 1))
      else $error("more than one slot claimed");

   // a response is loaded only from the last sequencer step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response loaded outside the finish step");

   // a reported frame length lies within a classic CAN payload
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free && done_assigned) |=>
         (rsp_data_ff[10:7] != 4'd0) && (rsp_data_ff[10:7] <= 4'(MAX_LEN)))
      else $error("frame length out of range");

endmodule

/* verif/csfa_placement_checker.sv */
// Response checker for can_signal_frame_assigner: tracks the frame slot table from
// the request transfers and compares each response transfer. Uses csfa_pkg.
module csfa_placement_checker #(
   parameter int NUM_SIGNALS = csfa_pkg::CSFA_NUM_SIGNALS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [csfa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [csfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              mismatch_count,
   output int                              awaited_count
);

   typedef struct packed {
      logic       assigned;
      logic [4:0] slot;
      logic       reused;
      logic [3:0] frame_length;
      logic       length_error;
   } placement_type;

   csfa_pkg::entry_type frame_slots [NUM_SIGNALS];
   placement_type       placements_due [$];
   int                  response_count;

   function automatic void empty_frame_slots();
      for (int j = 0; j < NUM_SIGNALS; j++) begin
         frame_slots[j] = '0;
      end
   endfunction

   // Place one signal description in the slot table and return the answer.
   function automatic placement_type place_signal(logic first, logic [4:0] idx,
                                                  logic enabled, logic ext,
                                                  logic [csfa_pkg::ID_W-1:0] id,
                                                  logic [5:0] start, logic [6:0] nbits);
      placement_type p;
      logic [7:0] total;
      logic [7:0] last_bit;
      logic [4:0] bytes;
      logic [3:0] need;
      logic       clamped;
      int         hit;
      p   = '0;
      hit = -1;
      if (first) begin
         empty_frame_slots();
      end
      total    = 8'(start) + 8'(nbits);
      last_bit = total - 8'd1;
      // a zero total would wrap the last bit to -1, so it is caught first and given one byte
      bytes    = (total == 8'd0) ? 5'd1 : last_bit[7:3] + 5'd1;
      clamped  = int'(bytes) > csfa_pkg::MAX_LEN;
      need     = clamped ? 4'(csfa_pkg::MAX_LEN) : bytes[3:0];
      if (int'(idx) < NUM_SIGNALS && enabled) begin
         for (int j = 0; j < NUM_SIGNALS && hit < 0; j++) begin
            if (frame_slots[j].len != '0 && frame_slots[j].ext == ext &&
                frame_slots[j].id == id) begin
               hit = j;
            end
         end
         if (hit >= 0) begin
            p.reused = 1'b1;
            if (frame_slots[hit].len < need) begin
               frame_slots[hit].len = need;
            end
         end else begin
            for (int j = 0; j < NUM_SIGNALS && hit < 0; j++) begin
               if (frame_slots[j].len == '0) begin
                  hit = j;
               end
            end
            if (hit >= 0) begin
               frame_slots[hit].len = need;
               frame_slots[hit].ext = ext;
               frame_slots[hit].id  = id;
            end
         end
         if (hit >= 0) begin
            p.assigned     = 1'b1;
            p.slot         = hit[4:0];
            p.frame_length = frame_slots[hit].len;
            p.length_error = clamped;
         end
      end
      if (!p.assigned) begin
         p.reused = 1'b0;
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("csfa checker: response %0d, %s: got %0d, expected %0d",
               response_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_placement(logic [csfa_pkg::RSP_DATA_W-1:0] data);
      placement_type want;
      placement_type got;
      got = {data[0], data[5:1], data[6], data[10:7], data[11]};
      if (placements_due.size() == 0) begin
         report_mismatch("response with nothing outstanding", int'(got), 0);
      end else begin
         want = placements_due.pop_front();
         if (got.assigned != want.assigned)
            report_mismatch("assigned", got.assigned, want.assigned);
         if (got.slot != want.slot)
            report_mismatch("slot", got.slot, want.slot);
         if (got.reused != want.reused)
            report_mismatch("reused", got.reused, want.reused);
         if (got.frame_length != want.frame_length)
            report_mismatch("frame_length", got.frame_length, want.frame_length);
         if (got.length_error != want.length_error)
            report_mismatch("length_error", got.length_error, want.length_error);
      end
      response_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         empty_frame_slots();
         placements_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_placement(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            placements_due.push_back(place_signal(req_tdata[0], req_tdata[5:1], req_tdata[6],
                                                  req_tuser, req_tdata[35:7],
                                                  req_tdata[41:36], req_tdata[48:42]));
         end
      end
      awaited_count = placements_due.size();
   end

endmodule

/* verif/tb_can_signal_frame_assigner.sv */
// Testbench top for can_signal_frame_assigner: clock, reset, request stimulus,
// response back-pressure and the verdict. Uses csfa_pkg and csfa_placement_checker.
module tb_can_signal_frame_assigner;

   localparam int IDLE_PERCENT = 21;
   localparam int ITEM_TARGET  = 1750;
   // worst item: full scan plus sender gap plus response stall, many times over
   localparam int CYCLE_LIMIT  = 600000;
   // tail after the last response, sized from the scan length
   localparam int DRAIN_CYCLES = 2 * (csfa_pkg::CSFA_NUM_SIGNALS + 2);

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [csfa_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [csfa_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            steady     = 1'b0;   // no idling on either side
   int                              mismatch_count;
   int                              awaited_count;
   int                              cycle_count;
   int                              sent_count;

   can_signal_frame_assigner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   csfa_placement_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stall the response side at random, except during the steady stretch.
   initial begin
      forever begin
         @(negedge clock);
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Hard stop in case a response never shows up.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("can_signal_frame_assigner verification failed");
      $finish;
   end

   // Drive one signal description and hold it until its transfer. Called and
   // returns at a falling edge; valid stays high when the next item follows
   // with no gap, so it is never lowered and raised in one step.
   task automatic issue_request(logic first, logic [4:0] idx, logic enabled, logic ext,
                                logic [28:0] id, logic [5:0] start, logic [6:0] nbits);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ext;
      // pack from bit 0 up: first, index, enabled, identifier, start, length
      req_tdata  <= {7'd0, nbits, start, id, enabled, idx, first};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_count++;
   endtask

   // Hold off new requests until every outstanding response has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (awaited_count != 0) @(negedge clock);
   endtask

   // One set-up session: "first" opens it, identifiers come from a small pool
   // so frames get shared, with some noise (stray clears, format flips,
   // unrelated identifiers, odd widths) mixed in.
   task automatic run_session(int items, int pool_size);
      logic [28:0] pool_id  [48];
      logic        pool_ext [48];
      logic [28:0] id;
      logic        ext;
      logic [5:0]  start;
      logic [6:0]  nbits;
      int          pick;
      bit          noise;
      for (int k = 0; k < pool_size; k++) begin
         pool_ext[k] = 1'($urandom_range(0, 1));
         if (pool_ext[k] || $urandom_range(0, 3) == 0)
            pool_id[k] = 29'($urandom);
         else
            pool_id[k] = 29'($urandom_range(0, 2047));
      end
      for (int n = 0; n < items; n++) begin
         pick  = $urandom_range(0, pool_size - 1);
         noise = $urandom_range(0, 99) < 10;
         id    = pool_id[pick];
         ext   = pool_ext[pick];
         if (noise) begin
            if ($urandom_range(0, 1) == 1) ext = ~ext;
            else id = 29'($urandom);
         end
         start = 6'($urandom_range(0, 63));
         if ($urandom_range(0, 9) == 0)
            nbits = 7'($urandom_range(0, 127));
         else
            nbits = 7'($urandom_range(1, 64 - int'(start)));
         issue_request(n == 0 || (noise && $urandom_range(0, 3) == 0),
                       5'($urandom_range(0, 31)), $urandom_range(0, 19) != 0,
                       ext, id, start, nbits);
      end
   endtask

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: new frame, growth on reuse, format mismatch, widest identifier,
      // zero-width signal, clamping, disabled signal, no shrinking, a repeated
      // description, a clear carried by a disabled item, exactly eight bytes.
      issue_request(1'b1, 5'd0,  1'b1, 1'b0, 29'h0,        6'd0,  7'd1);
      issue_request(1'b0, 5'd1,  1'b1, 1'b0, 29'h0,        6'd56, 7'd8);
      issue_request(1'b0, 5'd2,  1'b1, 1'b1, 29'h0,        6'd0,  7'd8);
      issue_request(1'b0, 5'd3,  1'b1, 1'b1, 29'h1FFFFFFF, 6'd63, 7'd64);
      issue_request(1'b0, 5'd4,  1'b1, 1'b0, 29'h7FF,      6'd0,  7'd0);
      issue_request(1'b0, 5'd5,  1'b1, 1'b0, 29'h7FF,      6'd63, 7'd127);
      issue_request(1'b0, 5'd6,  1'b0, 1'b0, 29'h7FF,      6'd0,  7'd8);
      issue_request(1'b0, 5'd7,  1'b1, 1'b0, 29'h0,        6'd0,  7'd1);
      issue_request(1'b0, 5'd0,  1'b1, 1'b0, 29'h12345,    6'd8,  7'd16);
      issue_request(1'b0, 5'd31, 1'b1, 1'b1, 29'h15555555, 6'd32, 7'd33);
      issue_request(1'b1, 5'd31, 1'b0, 1'b1, 29'h15555555, 6'd32, 7'd33);
      issue_request(1'b0, 5'd0,  1'b1, 1'b1, 29'h0AAAAAAA, 6'd7,  7'd1);
      issue_request(1'b0, 5'd1,  1'b1, 1'b0, 29'h0AAAAAAA, 6'd0,  7'd9);
      issue_request(1'b0, 5'd2,  1'b0, 1'b1, 29'h0AAAAAAA, 6'd40, 7'd100);
      issue_request(1'b0, 5'd3,  1'b1, 1'b1, 29'h0AAAAAAA, 6'd0,  7'd64);

      // Fill every slot with its own identifier, then overflow the table.
      for (int k = 0; k < csfa_pkg::CSFA_NUM_SIGNALS + 3; k++) begin
         issue_request(k == 0, 5'(k), 1'b1, 1'b0, 29'(k + 100), 6'(k), 7'd1);
      end

      while (sent_count < ITEM_TARGET) begin
         steady <= (sent_count >= 700 && sent_count < 1000);
         if (!paused && sent_count >= 400) begin
            wait_for_drain();
            paused = 1'b1;
         end
         if ($urandom_range(0, 4) == 0)
            run_session($urandom_range(33, 48), $urandom_range(30, 40));
         else
            run_session($urandom_range(1, 24), $urandom_range(1, 12));
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("can_signal_frame_assigner verification clean");
      end else begin
         $display("can_signal_frame_assigner verification failed");
      end
      $finish;
   end

endmodule
